FILE: rtl/tcs_pkg.sv
package tcs_pkg;

  localparam int COLS        = 80;
  localparam int ROWS        = 25;
  localparam int STORE_LINES = 200;
  localparam int STORE_CELLS = STORE_LINES * COLS;
  localparam int HALF_CELLS  = (STORE_LINES / 2) * COLS;
  localparam int SCREEN_CELLS = COLS * ROWS;

  localparam int ADDR_W = $clog2(STORE_CELLS);
  localparam int LINE_W = $clog2(STORE_LINES + 1);
  localparam int COL_W  = $clog2(COLS);

  // cols is 16 * 5 and rows is 25, so line and screen numbers come from
  // reciprocal multiplication, exact for operands below 1024
  localparam int COL_SHIFT   = 4;
  localparam int DIV5_RECIP  = 205;
  localparam int DIV25_RECIP = 41;
  localparam int RECIP_SHIFT = 10;

  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  localparam logic [1:0] CFG_DEFAULT_FG = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_BG = 2'd1;

  typedef enum logic [2:0] {
    CMD_PUT_CHAR    = 3'd0,
    CMD_DELETE      = 3'd1,
    CMD_SCROLL_UP   = 3'd2,
    CMD_SCROLL_DOWN = 3'd3,
    CMD_CLEAR       = 3'd4,
    CMD_SET_CURSOR  = 3'd5,
    CMD_WRITE_CELL  = 3'd6,
    CMD_READ_SCREEN = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  char_code;
    logic [13:0] position;
    logic [3:0]  cell_fg;
    logic [3:0]  cell_bg;
  } cmd_item_t;

  typedef struct packed {
    logic [13:0] cursor_index;
    logic [7:0]  window_start;
    logic [10:0] hw_cursor;
    logic [7:0]  view_back;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
  } result_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_READ_WAIT,
    ST_CLEAR,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_BLANK,
    ST_FINISH
  } state_t;

endpackage

FILE: rtl/tcs_stream_if.sv
interface tcs_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/tcs_front.sv
module tcs_front
  import tcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cmd_item_t in_item,
  output logic      q_valid,
  input  logic      q_pop,
  output cmd_item_t q_item
);

  // two-entry queue
  cmd_item_t  slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= in_item;
  end

endmodule

FILE: rtl/tcs_back.sv
module tcs_back
  import tcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [3:0]       def_fg,
  input  logic [3:0]       def_bg,
  input  logic             q_valid,
  output logic             q_pop,
  input  cmd_item_t        q_item,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res_data
);

  logic [15:0] mem [STORE_CELLS];
  logic [15:0] rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wr_data;
  logic              wr_en;

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [7:0]  back_r, back_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic        rd_ok_r, rd_ok_nxt;
  cmd_item_t   item_r;
  logic        res_valid_r;
  result_t     res_r;

  // cursor line and screen offset, and row and column of a read position, by division by a constant
  logic [ADDR_W+7:0] line_prod;
  logic [ADDR_W+7:0] pos_prod;
  logic [LINE_W+5:0] scr_prod;
  logic [ADDR_W-1:0] hw_pos;
  logic [LINE_W-1:0] cur_line;
  logic [ADDR_W-1:0] line_base;
  logic [15:0]       blank_cell, typed_cell;
  logic signed [LINE_W+9:0] first_s;
  logic [LINE_W-1:0] first_line;
  logic [4:0]        pos_row;
  logic [COL_W-1:0]  pos_col;
  logic [ADDR_W+1:0] read_idx;
  logic [ADDR_W:0]   newline_cur;

  // x / 80 == ((x >> 4) * 205) >> 10
  assign line_prod = (ADDR_W+8)'(cursor_r[ADDR_W-1:COL_SHIFT]) * (ADDR_W+8)'(DIV5_RECIP);
  assign cur_line  = line_prod[LINE_W+RECIP_SHIFT-1:RECIP_SHIFT];
  assign line_base = ADDR_W'(cur_line * COLS);
  // cursor modulo the screen: screen number is line / 25
  assign scr_prod  = (LINE_W+6)'(cur_line) * (LINE_W+6)'(DIV25_RECIP);
  assign hw_pos    = cursor_r - ADDR_W'(scr_prod[LINE_W+5:RECIP_SHIFT] * SCREEN_CELLS);
  assign blank_cell = {def_fg, def_bg, SPACE_CHAR};
  assign typed_cell = {def_fg, def_bg, item_r.char_code};
  assign first_s = $signed({{10{1'b0}}, cur_line}) - (LINE_W+10)'(ROWS - 1)
                   - $signed({{(LINE_W+2){1'b0}}, back_r});
  assign first_line = first_s[LINE_W+9] ? '0 : LINE_W'(first_s);
  assign pos_prod = (ADDR_W+8)'(item_r.position[13:COL_SHIFT]) * (ADDR_W+8)'(DIV5_RECIP);
  assign pos_row  = pos_prod[RECIP_SHIFT+4:RECIP_SHIFT];
  assign pos_col = COL_W'(item_r.position - 14'(pos_row * COLS));
  assign read_idx = (ADDR_W+2)'((first_line + pos_row) * COLS) + (ADDR_W+2)'(pos_col);
  assign newline_cur = (ADDR_W+1)'(line_base) + (ADDR_W+1)'(COLS);

  always_comb begin
    unique case (state_r)
      ST_INIT:   state_nxt = (idx_r == ADDR_W'(STORE_CELLS-1)) ? ST_IDLE : ST_INIT;
      ST_IDLE:   state_nxt = (q_valid && !res_valid_r) ? ST_DECODE : ST_IDLE;
      ST_DECODE: begin
        unique case (item_r.cmd)
          CMD_CLEAR:       state_nxt = ST_CLEAR;
          CMD_READ_SCREEN: state_nxt = ST_READ_WAIT;
          CMD_PUT_CHAR: begin
            if ((item_r.char_code == NEWLINE_CHAR &&
                 newline_cur >= (ADDR_W+1)'(STORE_CELLS)) ||
                (item_r.char_code != NEWLINE_CHAR &&
                 cursor_r >= ADDR_W'(STORE_CELLS-1)))
              state_nxt = ST_COPY_RD;
            else
              state_nxt = ST_FINISH;
          end
          default:         state_nxt = ST_FINISH;
        endcase
      end
      ST_READ_WAIT: state_nxt = ST_FINISH;
      ST_CLEAR:  state_nxt = (idx_r == ADDR_W'(STORE_CELLS-1)) ? ST_FINISH : ST_CLEAR;
      ST_COPY_RD: state_nxt = ST_COPY_WR;
      ST_COPY_WR: state_nxt = (idx_r == ADDR_W'(HALF_CELLS-1)) ? ST_BLANK : ST_COPY_RD;
      ST_BLANK:  state_nxt = (idx_r == ADDR_W'(STORE_CELLS-1)) ? ST_FINISH : ST_BLANK;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cursor_nxt = cursor_r;
    back_nxt   = back_r;
    idx_nxt    = idx_r;
    rd_ok_nxt  = rd_ok_r;
    rd_en      = 1'b0;
    rd_addr    = idx_r + ADDR_W'(HALF_CELLS);
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = blank_cell;
    q_pop      = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        wr_en   = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      ST_IDLE: begin
        q_pop = q_valid && !res_valid_r;
      end
      ST_DECODE: begin
        idx_nxt = '0;
        unique case (item_r.cmd)
          CMD_PUT_CHAR: begin
            back_nxt = '0;
            if (item_r.char_code == NEWLINE_CHAR) begin
              cursor_nxt = (newline_cur >= (ADDR_W+1)'(STORE_CELLS)) ?
                           ADDR_W'(newline_cur - (ADDR_W+1)'(HALF_CELLS)) :
                           ADDR_W'(newline_cur);
            end else begin
              wr_en   = 1'b1;
              wr_addr = cursor_r;
              wr_data = typed_cell;
              cursor_nxt = (cursor_r >= ADDR_W'(STORE_CELLS-1)) ?
                           ADDR_W'(cursor_r + 1'b1 - ADDR_W'(HALF_CELLS)) :
                           cursor_r + 1'b1;
            end
          end
          CMD_DELETE: begin
            if (cursor_r != '0) begin
              cursor_nxt = cursor_r - 1'b1;
              wr_en   = 1'b1;
              wr_addr = cursor_r - 1'b1;
            end
          end
          CMD_SCROLL_UP: begin
            if ({1'b0, cur_line} > (LINE_W+1)'(ROWS) + (LINE_W+1)'(back_r))
              back_nxt = back_r + 1'b1;
          end
          CMD_SCROLL_DOWN: begin
            if (back_r != '0) back_nxt = back_r - 1'b1;
          end
          CMD_CLEAR: begin
            cursor_nxt = '0;
            back_nxt   = '0;
          end
          CMD_SET_CURSOR: begin
            cursor_nxt = (item_r.position < 14'(STORE_CELLS)) ?
                         ADDR_W'(item_r.position) : ADDR_W'(STORE_CELLS-1);
          end
          CMD_WRITE_CELL: begin
            if (item_r.position < 14'(STORE_CELLS)) begin
              wr_en   = 1'b1;
              wr_addr = ADDR_W'(item_r.position);
              wr_data = {item_r.cell_fg, item_r.cell_bg, item_r.char_code};
            end
          end
          CMD_READ_SCREEN: begin
            rd_ok_nxt = (item_r.position < 14'(SCREEN_CELLS)) &&
                        (read_idx < (ADDR_W+2)'(STORE_CELLS));
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(read_idx);
          end
          default: ;
        endcase
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      ST_COPY_RD: begin
        rd_en = 1'b1;
      end
      ST_COPY_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data_r;
        idx_nxt = (idx_r == ADDR_W'(HALF_CELLS-1)) ? ADDR_W'(HALF_CELLS) : idx_r + 1'b1;
      end
      ST_BLANK: begin
        wr_en   = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_item;
    if (state_r == ST_FINISH) begin
      res_r.cursor_index <= 14'(cursor_r);
      res_r.window_start <= 8'(first_line);
      res_r.hw_cursor    <= (back_r == '0) ? 11'(hw_pos) : 11'(SCREEN_CELLS);
      res_r.view_back    <= back_r;
      if (item_r.cmd == CMD_READ_SCREEN && rd_ok_r) begin
        res_r.read_char <= rd_data_r[7:0];
        res_r.read_attr <= rd_data_r[15:8];
      end else begin
        res_r.read_char <= '0;
        res_r.read_attr <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cursor_r    <= '0;
      back_r      <= '0;
      idx_r       <= '0;
      rd_ok_r     <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      back_r   <= back_nxt;
      idx_r    <= idx_nxt;
      rd_ok_r  <= rd_ok_nxt;
      if (state_r == ST_FINISH)   res_valid_r <= 1'b1;
      else if (res_ready)         res_valid_r <= 1'b0;
    end
  end

  assign res_valid = res_valid_r;
  assign res_data  = res_r;

endmodule

FILE: rtl/text_console_scrollback.sv
// channel  | dir | handshake         | payload
// in       | in  | in.valid/ready    | cmd, char_code, position, cell_fg, cell_bg
// out      | out | out.valid/ready   | cursor_index .. read_attr
// cfg      | in  | cfg_we            | cfg_index, cfg_wdata (4 bits)
// an ordinary command goes from queue head to result through idle (pop), decode and finish
// read_screen adds a read-wait state for the registered store read
// clear and reset walk all 16000 cells, one per cycle; a wrap copies each upper-half cell
// down (read state, write state), blanks the upper half; no command starts until init ends
// a waiting result holds the back end; the two-entry queue keeps taking commands until full
module text_console_scrollback
  import tcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  tcs_stream_if.sink   in,
  tcs_stream_if.source out,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [3:0] cfg_wdata
);

  logic [3:0] def_fg_r, def_bg_r;
  logic       q_valid, q_pop;
  cmd_item_t  q_item, in_item;
  result_t    res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_fg_r <= 4'd15;
      def_bg_r <= 4'd0;
    end else if (cfg_we) begin
      if ({1'b0, cfg_index} == CFG_DEFAULT_FG) def_fg_r <= cfg_wdata;
      if ({1'b0, cfg_index} == CFG_DEFAULT_BG) def_bg_r <= cfg_wdata;
    end
  end

  assign in_item = in.data;

  tcs_front u_front (
    .clk, .rst_n,
    .in_valid(in.valid), .in_ready(in.ready), .in_item,
    .q_valid, .q_pop, .q_item
  );

  tcs_back u_back (
    .clk, .rst_n,
    .def_fg(def_fg_r), .def_bg(def_bg_r),
    .q_valid, .q_pop, .q_item,
    .res_valid(out.valid), .res_ready(out.ready), .res_data(res)
  );

  assign out.data = res;

endmodule
